### hdl/e2r_pkg.sv
// Package for the Euler pose to rotation matrix block.
// Holds widths, CORDIC constants, convention codes and arithmetic helpers.
// No dependencies.
package e2r_pkg;

  localparam int AngleFracBits = 8;
  localparam int CoefFracBits  = 14;
  localparam int CordicSteps   = 16;

  localparam int AngleW = 18;
  localparam int PosW   = 32;
  localparam int CoefW  = 16;
  localparam int QW     = 33;
  localparam int ZW     = 34;

  localparam logic signed [QW-1:0] GainQ30 = 33'sd652032874;

  typedef enum logic [1:0] {
    CONV_XYZ      = 2'd0,
    CONV_ZYX      = 2'd1,
    CONV_FIXED    = 2'd2,
    CONV_RESERVED = 2'd3
  } conv_e;

  typedef struct packed {
    logic signed [QW-1:0] x;
    logic signed [QW-1:0] y;
    logic signed [ZW-1:0] z;
    logic                 neg;
  } cstate_t;

  function automatic logic signed [ZW-1:0] atan_f(input int k);
    logic signed [ZW-1:0] t;
    begin
      case (k)
        0: t = 34'sd536870912;   1: t = 34'sd316933406;
        2: t = 34'sd167458907;   3: t = 34'sd85004756;
        4: t = 34'sd42667331;    5: t = 34'sd21354465;
        6: t = 34'sd10679838;    7: t = 34'sd5340245;
        8: t = 34'sd2670163;     9: t = 34'sd1335087;
        10: t = 34'sd667544;     11: t = 34'sd333772;
        12: t = 34'sd166886;     13: t = 34'sd83443;
        14: t = 34'sd41722;      15: t = 34'sd20861;
        16: t = 34'sd10430;      17: t = 34'sd5215;
        18: t = 34'sd2608;       19: t = 34'sd1304;
        20: t = 34'sd652;        21: t = 34'sd326;
        22: t = 34'sd163;        23: t = 34'sd81;
        24: t = 34'sd41;         25: t = 34'sd20;
        26: t = 34'sd10;         27: t = 34'sd5;
        28: t = 34'sd3;          29: t = 34'sd1;
        30: t = 34'sd1;
        default: t = 34'sd0;
      endcase
      return t;
    end
  endfunction

  // Q30 product floored back to Q30
  function automatic logic signed [QW-1:0] mulq(input logic signed [QW-1:0] a,
                                                input logic signed [QW-1:0] b);
    logic signed [2*QW-1:0] p;
    begin
      p = a * b;
      return p[QW+29:30];
    end
  endfunction

endpackage

### hdl/e2r_cordic.sv
// Pipelined sine/cosine CORDIC, one register stage per iteration.
// Angle scaling to a binary angle in front, sign fixup at the end. Uses e2r_pkg.
module e2r_cordic #(
  parameter int ANGLE_FRAC_BITS = e2r_pkg::AngleFracBits,
  parameter int CORDIC_STEPS    = e2r_pkg::CordicSteps
) (
  input  logic                                 clk_i,
  input  logic                                 en_i,
  input  logic signed [e2r_pkg::AngleW-1:0]    ang_i,
  output logic signed [e2r_pkg::QW-1:0]        sin_o,
  output logic signed [e2r_pkg::QW-1:0]        cos_o
);
  localparam int Full = 360 * (2 ** ANGLE_FRAC_BITS);
  // whole turns added so that every input angle becomes non-negative
  localparam int Offs = ((2 ** (e2r_pkg::AngleW - 1) + Full - 1) / Full) * Full;
  // 2^32 / Full = 2^Sc / 45 = QC + RmC / 45
  localparam int Sc  = 29 - ANGLE_FRAC_BITS;
  localparam int QC  = (2 ** Sc) / 45;
  localparam int RmC = (2 ** Sc) % 45;
  localparam int RW  = 21;
  localparam int TW  = 27;
  // ceil(2^31 / 45): exact floor division by 45 for operands below 2^27
  localparam logic [25:0] RecipM = 26'd47721859;

  // stage A: lift into positive range, remainder term product
  logic signed [31:0] a_ext;
  logic [RW-1:0] r_d, r_q;
  logic [TW-1:0] t_d, t_q;
  always_comb begin
    a_ext = 32'(ang_i) + 32'(Offs);
    r_d   = RW'(a_ext);
    t_d   = TW'(32'(r_d) * 32'(RmC));
  end
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      r_q <= r_d;
      t_q <= t_d;
    end
  end

  // stage B: binary angle modulo one turn, quadrant fold
  logic [52:0] tm;
  logic [31:0] zb;
  logic signed [e2r_pkg::ZW-1:0] z0;
  e2r_pkg::cstate_t st0;
  always_comb begin
    tm  = 53'(t_q) * 53'(RecipM);
    zb  = 32'(r_q) * 32'(QC) + 32'(tm >> 31);
    z0  = e2r_pkg::ZW'($signed(zb));
    st0.neg = 1'b0;
    if (z0 > (e2r_pkg::ZW)'(64'sd1073741824)) begin
      z0 = z0 - (e2r_pkg::ZW)'(64'sd2147483648);
      st0.neg = 1'b1;
    end else if (z0 < -(e2r_pkg::ZW)'(64'sd1073741824)) begin
      z0 = z0 + (e2r_pkg::ZW)'(64'sd2147483648);
      st0.neg = 1'b1;
    end
    st0.x = e2r_pkg::GainQ30;
    st0.y = '0;
    st0.z = z0;
  end

  e2r_pkg::cstate_t st_q [CORDIC_STEPS+1];
  e2r_pkg::cstate_t nx [CORDIC_STEPS];

  always_comb begin
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      nx[i] = st_q[i];
      if (st_q[i].z >= 0) begin
        nx[i].x = st_q[i].x - (st_q[i].y >>> (i % 32));
        nx[i].y = st_q[i].y + (st_q[i].x >>> (i % 32));
        nx[i].z = st_q[i].z - e2r_pkg::atan_f(i % 32);
      end else begin
        nx[i].x = st_q[i].x + (st_q[i].y >>> (i % 32));
        nx[i].y = st_q[i].y - (st_q[i].x >>> (i % 32));
        nx[i].z = st_q[i].z + e2r_pkg::atan_f(i % 32);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      st_q[0] <= st0;
      for (int i = 0; i < CORDIC_STEPS; i++) st_q[i+1] <= nx[i];
    end
  end

  assign sin_o = st_q[CORDIC_STEPS].neg ? -st_q[CORDIC_STEPS].y : st_q[CORDIC_STEPS].y;
  assign cos_o = st_q[CORDIC_STEPS].neg ? -st_q[CORDIC_STEPS].x : st_q[CORDIC_STEPS].x;
endmodule

### hdl/euler_to_rotation_matrix_top.sv
// Euler pose to 3x4 homogeneous transform, top level.
// Throughput one pose per cycle while the output is not stalled.
// A global stall freezes all stages; valid bits travel with the data.
// Reset clears valid bits and sets the convention register to mobile XYZ.
// Depends on e2r_pkg and e2r_cordic.
module euler_to_rotation_matrix_top #(
  parameter int ANGLE_FRAC_BITS = e2r_pkg::AngleFracBits,
  parameter int COEF_FRAC_BITS  = e2r_pkg::CoefFracBits,
  parameter int CORDIC_STEPS    = e2r_pkg::CordicSteps
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic signed [31:0] pos_x_i,
  input  logic signed [31:0] pos_y_i,
  input  logic signed [31:0] pos_z_i,
  input  logic signed [17:0] angle_first_i,
  input  logic signed [17:0] angle_second_i,
  input  logic signed [17:0] angle_third_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic signed [15:0] rot_00_o,
  output logic signed [15:0] rot_01_o,
  output logic signed [15:0] rot_02_o,
  output logic signed [15:0] rot_10_o,
  output logic signed [15:0] rot_11_o,
  output logic signed [15:0] rot_12_o,
  output logic signed [15:0] rot_20_o,
  output logic signed [15:0] rot_21_o,
  output logic signed [15:0] rot_22_o,
  output logic signed [31:0] out_x_o,
  output logic signed [31:0] out_y_o,
  output logic signed [31:0] out_z_o
);
  localparam int QW = e2r_pkg::QW;
  localparam int Depth = CORDIC_STEPS + 6;
  localparam int CordLat = CORDIC_STEPS + 2;

  logic [1:0] conv_q;
  logic en;
  logic [Depth-1:0] vld_q;

  assign en = !(vld_q[Depth-1] && out_stall_i);
  assign in_stall_o = !en;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      conv_q <= e2r_pkg::CONV_XYZ;
      vld_q  <= '0;
    end else begin
      if (cfg_valid_i) conv_q <= cfg_data_i;
      if (en) vld_q <= {vld_q[Depth-2:0], in_valid_i};
    end
  end

  e2r_pkg::conv_e conv;
  assign conv = e2r_pkg::conv_e'(conv_q);

  // angle role selection at the input
  logic signed [17:0] ang_a, ang_c;
  logic zyx_form;
  always_comb begin
    ang_a = angle_first_i;
    ang_c = angle_third_i;
    zyx_form = 1'b0;
    case (conv)
      e2r_pkg::CONV_ZYX: begin
        ang_a = angle_third_i;
        ang_c = angle_first_i;
        zyx_form = 1'b1;
      end
      e2r_pkg::CONV_FIXED: zyx_form = 1'b1;
      default: zyx_form = 1'b0;
    endcase
  end

  logic signed [QW-1:0] sa, ca, sb, cb, sc, cc;
  e2r_cordic #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS), .CORDIC_STEPS(CORDIC_STEPS)) u_ca (
    .clk_i, .en_i(en), .ang_i(ang_a), .sin_o(sa), .cos_o(ca));
  e2r_cordic #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS), .CORDIC_STEPS(CORDIC_STEPS)) u_cb (
    .clk_i, .en_i(en), .ang_i(angle_second_i), .sin_o(sb), .cos_o(cb));
  e2r_cordic #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS), .CORDIC_STEPS(CORDIC_STEPS)) u_cc (
    .clk_i, .en_i(en), .ang_i(ang_c), .sin_o(sc), .cos_o(cc));

  // side data delay line
  logic [95:0] pos_q [Depth];
  logic form_q [Depth];
  always_ff @(posedge clk_i) begin
    if (en) begin
      pos_q[0]  <= {pos_x_i, pos_y_i, pos_z_i};
      form_q[0] <= zyx_form;
      for (int i = 1; i < Depth; i++) begin
        pos_q[i]  <= pos_q[i-1];
        form_q[i] <= form_q[i-1];
      end
    end
  end

  // stage P1: first products
  logic signed [QW-1:0] p1_sasb_q, p1_casb_q, p1_sb_q;
  logic signed [QW-1:0] p1_sc_q, p1_cc_q, p1_cbcc_q, p1_cbsc_q, p1_sacb_q, p1_cacb_q;
  logic signed [QW-1:0] p1_casc_q, p1_cacc_q, p1_sasc_q, p1_sacc_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      p1_sasb_q <= e2r_pkg::mulq(sa, sb);
      p1_casb_q <= e2r_pkg::mulq(ca, sb);
      p1_cbcc_q <= e2r_pkg::mulq(cb, cc);
      p1_cbsc_q <= e2r_pkg::mulq(cb, sc);
      p1_sacb_q <= e2r_pkg::mulq(sa, cb);
      p1_cacb_q <= e2r_pkg::mulq(ca, cb);
      p1_casc_q <= e2r_pkg::mulq(ca, sc);
      p1_cacc_q <= e2r_pkg::mulq(ca, cc);
      p1_sasc_q <= e2r_pkg::mulq(sa, sc);
      p1_sacc_q <= e2r_pkg::mulq(sa, cc);
      p1_sb_q <= sb;
      p1_sc_q <= sc; p1_cc_q <= cc;
    end
  end

  // stage P2: three-factor products
  logic signed [QW-1:0] sasbcc_q, sasbsc_q, casbcc_q, casbsc_q;
  logic signed [QW-1:0] p2_cbcc_q, p2_cbsc_q, p2_sacb_q, p2_cacb_q, p2_sb_q;
  logic signed [QW-1:0] p2_casc_q, p2_cacc_q, p2_sasc_q, p2_sacc_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      sasbcc_q <= e2r_pkg::mulq(p1_sasb_q, p1_cc_q);
      sasbsc_q <= e2r_pkg::mulq(p1_sasb_q, p1_sc_q);
      casbcc_q <= e2r_pkg::mulq(p1_casb_q, p1_cc_q);
      casbsc_q <= e2r_pkg::mulq(p1_casb_q, p1_sc_q);
      p2_cbcc_q <= p1_cbcc_q; p2_cbsc_q <= p1_cbsc_q;
      p2_sacb_q <= p1_sacb_q; p2_cacb_q <= p1_cacb_q; p2_sb_q <= p1_sb_q;
      p2_casc_q <= p1_casc_q; p2_cacc_q <= p1_cacc_q;
      p2_sasc_q <= p1_sasc_q; p2_sacc_q <= p1_sacc_q;
    end
  end

  // stage S: sums per convention
  logic signed [QW:0] m_d [9];
  logic signed [QW:0] m_q [9];
  always_comb begin
    m_d[0] = (QW+1)'(p2_cbcc_q);
    m_d[8] = (QW+1)'(p2_cacb_q);
    if (form_q[CordLat+1]) begin
      m_d[1] = (QW+1)'(sasbcc_q) - (QW+1)'(p2_casc_q);
      m_d[2] = (QW+1)'(p2_sasc_q) + (QW+1)'(casbcc_q);
      m_d[3] = (QW+1)'(p2_cbsc_q);
      m_d[4] = (QW+1)'(p2_cacc_q) + (QW+1)'(sasbsc_q);
      m_d[5] = (QW+1)'(casbsc_q) - (QW+1)'(p2_sacc_q);
      m_d[6] = -(QW+1)'(p2_sb_q);
      m_d[7] = (QW+1)'(p2_sacb_q);
    end else begin
      m_d[1] = -(QW+1)'(p2_cbsc_q);
      m_d[2] = (QW+1)'(p2_sb_q);
      m_d[3] = (QW+1)'(p2_casc_q) + (QW+1)'(sasbcc_q);
      m_d[4] = (QW+1)'(p2_cacc_q) - (QW+1)'(sasbsc_q);
      m_d[5] = -(QW+1)'(p2_sacb_q);
      m_d[6] = (QW+1)'(p2_sasc_q) - (QW+1)'(casbcc_q);
      m_d[7] = (QW+1)'(p2_sacc_q) + (QW+1)'(casbsc_q);
    end
  end
  always_ff @(posedge clk_i) begin
    if (en) m_q <= m_d;
  end

  // stage R: round and saturate
  localparam int Sh = 30 - COEF_FRAC_BITS;
  localparam logic signed [QW+1:0] One = (QW+2)'(64'sd1 << COEF_FRAC_BITS);
  logic signed [15:0] c_d [9];
  logic signed [15:0] c_q [9];
  always_comb begin
    for (int j = 0; j < 9; j++) begin
      logic signed [QW+1:0] v, q;
      v = (QW+2)'(m_q[j]);
      if (Sh > 0) v = v + (QW+2)'(64'sd1 << (Sh > 0 ? Sh - 1 : 0));
      q = v >>> Sh;
      if (q > One) q = One;
      if (q < -One) q = -One;
      c_d[j] = q[15:0];
    end
  end
  always_ff @(posedge clk_i) begin
    if (en) c_q <= c_d;
  end

  assign out_valid_o = vld_q[Depth-1];
  assign rot_00_o = c_q[0]; assign rot_01_o = c_q[1]; assign rot_02_o = c_q[2];
  assign rot_10_o = c_q[3]; assign rot_11_o = c_q[4]; assign rot_12_o = c_q[5];
  assign rot_20_o = c_q[6]; assign rot_21_o = c_q[7]; assign rot_22_o = c_q[8];
  assign out_x_o = pos_q[Depth-1][95:64];
  assign out_y_o = pos_q[Depth-1][63:32];
  assign out_z_o = pos_q[Depth-1][31:0];

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(rot_00_o) && $stable(out_x_o))
    else $error("output changed under stall");
  a_stall_only_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("stall without full output");
  a_rot22_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> rot_22_o <= 16'sd16384 && rot_22_o >= -16'sd16384)
    else $error("entry out of range");
endmodule
